FILE: hw/rtl/jbs_pkg.sv
// jbs_pkg: shared types, register-file slots and the finish program for the
// Jarque-Bera block. No dependencies.
package jbs_pkg;

	localparam int W = 192;           // exact-integer datapath width
	localparam int PC_BITS = 6;
	localparam int RA_BITS = 4;
	localparam int IMM_BITS = 17;

	typedef logic [W-1:0] wide_t;
	typedef logic [PC_BITS-1:0] pc_t;
	typedef logic [RA_BITS-1:0] raddr_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 op;
		raddr_t              dst;
		raddr_t              ra;
		raddr_t              rb;
		logic                use_imm;
		logic [IMM_BITS-1:0] imm;
	} instr_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic pipe_busy;
		logic at_cap;
	} acc_status_t;

	// register-file slots
	localparam raddr_t R_N    = 4'd0;
	localparam raddr_t R_S1   = 4'd1;
	localparam raddr_t R_S2   = 4'd2;
	localparam raddr_t R_S3   = 4'd3;
	localparam raddr_t R_S4   = 4'd4;
	localparam raddr_t R_A    = 4'd5;
	localparam raddr_t R_S1SQ = 4'd6;
	localparam raddr_t R_M2   = 4'd7;
	localparam raddr_t R_M3   = 4'd8;
	localparam raddr_t R_B    = 4'd9;
	localparam raddr_t R_C    = 4'd10;
	localparam raddr_t R_D    = 4'd11;
	localparam raddr_t R_E    = 4'd12;
	localparam raddr_t R_Q    = 4'd13;

	localparam logic [IMM_BITS-1:0] K2     = 17'd2;
	localparam logic [IMM_BITS-1:0] K3     = 17'd3;
	localparam logic [IMM_BITS-1:0] K4     = 17'd4;
	localparam logic [IMM_BITS-1:0] K6     = 17'd6;
	localparam logic [IMM_BITS-1:0] K24    = 17'd24;
	localparam logic [IMM_BITS-1:0] KQ16   = 17'd65536;
	localparam logic [IMM_BITS-1:0] K_NONE = 17'd0;

	localparam pc_t PC_M2   = 6'd2;
	localparam pc_t PC_LAST = 6'd37;

	function automatic instr_t mk(op_t op, raddr_t d, raddr_t a, raddr_t b,
		logic ui, logic [IMM_BITS-1:0] im);
		instr_t r;
		r.op = op;
		r.dst = d;
		r.ra = a;
		r.rb = b;
		r.use_imm = ui;
		r.imm = im;
		return r;
	endfunction

	function automatic instr_t prog(pc_t pc);
		instr_t r;
		case (pc)
			// M2 = n*s2 - s1^2
			6'd0:  r = mk(OP_MUL, R_A,    R_N,    R_S2,   1'b0, K_NONE);
			6'd1:  r = mk(OP_MUL, R_S1SQ, R_S1,   R_S1,   1'b0, K_NONE);
			6'd2:  r = mk(OP_SUB, R_M2,   R_A,    R_S1SQ, 1'b0, K_NONE);
			// M3 = n^2*s3 - 3n*s1*s2 + 2*s1^3
			6'd3:  r = mk(OP_MUL, R_A,    R_N,    R_N,    1'b0, K_NONE);
			6'd4:  r = mk(OP_MUL, R_M3,   R_A,    R_S3,   1'b0, K_NONE);
			6'd5:  r = mk(OP_MUL, R_B,    R_N,    R_S1,   1'b0, K_NONE);
			6'd6:  r = mk(OP_MUL, R_C,    R_B,    R_S2,   1'b0, K_NONE);
			6'd7:  r = mk(OP_MUL, R_C,    R_C,    R_C,    1'b1, K3);
			6'd8:  r = mk(OP_SUB, R_M3,   R_M3,   R_C,    1'b0, K_NONE);
			6'd9:  r = mk(OP_MUL, R_C,    R_S1SQ, R_S1,   1'b0, K_NONE);
			6'd10: r = mk(OP_MUL, R_C,    R_C,    R_C,    1'b1, K2);
			6'd11: r = mk(OP_ADD, R_M3,   R_M3,   R_C,    1'b0, K_NONE);
			// M4 = n^3*s4 - 4n^2*s1*s3 + 6n*s1^2*s2 - 3*s1^4, left in R_C
			6'd12: r = mk(OP_MUL, R_C,    R_A,    R_N,    1'b0, K_NONE);
			6'd13: r = mk(OP_MUL, R_C,    R_C,    R_S4,   1'b0, K_NONE);
			6'd14: r = mk(OP_MUL, R_D,    R_A,    R_S1,   1'b0, K_NONE);
			6'd15: r = mk(OP_MUL, R_D,    R_D,    R_S3,   1'b0, K_NONE);
			6'd16: r = mk(OP_MUL, R_D,    R_D,    R_D,    1'b1, K4);
			6'd17: r = mk(OP_SUB, R_C,    R_C,    R_D,    1'b0, K_NONE);
			6'd18: r = mk(OP_MUL, R_D,    R_S1SQ, R_N,    1'b0, K_NONE);
			6'd19: r = mk(OP_MUL, R_D,    R_D,    R_S2,   1'b0, K_NONE);
			6'd20: r = mk(OP_MUL, R_D,    R_D,    R_D,    1'b1, K6);
			6'd21: r = mk(OP_ADD, R_C,    R_C,    R_D,    1'b0, K_NONE);
			6'd22: r = mk(OP_MUL, R_D,    R_S1SQ, R_S1SQ, 1'b0, K_NONE);
			6'd23: r = mk(OP_MUL, R_D,    R_D,    R_D,    1'b1, K3);
			6'd24: r = mk(OP_SUB, R_C,    R_C,    R_D,    1'b0, K_NONE);
			// num = 65536*n*((M4 - 3*M2^2)^2 + 4*M3^2*M2)
			6'd25: r = mk(OP_MUL, R_A,    R_M2,   R_M2,   1'b0, K_NONE);
			6'd26: r = mk(OP_MUL, R_D,    R_A,    R_A,    1'b1, K3);
			6'd27: r = mk(OP_SUB, R_D,    R_C,    R_D,    1'b0, K_NONE);
			6'd28: r = mk(OP_MUL, R_D,    R_D,    R_D,    1'b0, K_NONE);
			6'd29: r = mk(OP_MUL, R_E,    R_M3,   R_M3,   1'b0, K_NONE);
			6'd30: r = mk(OP_MUL, R_E,    R_E,    R_M2,   1'b0, K_NONE);
			6'd31: r = mk(OP_MUL, R_E,    R_E,    R_E,    1'b1, K4);
			6'd32: r = mk(OP_ADD, R_D,    R_D,    R_E,    1'b0, K_NONE);
			6'd33: r = mk(OP_MUL, R_D,    R_D,    R_N,    1'b0, K_NONE);
			6'd34: r = mk(OP_MUL, R_D,    R_D,    R_D,    1'b1, KQ16);
			// den = 24*M2^4, then divide
			6'd35: r = mk(OP_MUL, R_E,    R_A,    R_A,    1'b0, K_NONE);
			6'd36: r = mk(OP_MUL, R_E,    R_E,    R_E,    1'b1, K24);
			6'd37: r = mk(OP_DIV, R_Q,    R_D,    R_E,    1'b0, K_NONE);
			default: r = mk(OP_ADD, R_Q,  R_Q,    R_Q,    1'b0, K_NONE);
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/jbs_accum.sv
// jbs_accum: sample count and power sums of degree one to four, fed by a
// two-stage power pipeline. Depends on jbs_pkg.
module jbs_accum #(
	parameter int MAX_SAMPLES = 256,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   add,
	input  logic [11:0]            sample,
	input  logic                   clr,
	output jbs_pkg::acc_status_t   status,
	output logic [8:0]             count,
	output logic signed [19:0]     sum_first,
	output logic [30:0]            sum_second,
	output logic signed [41:0]     sum_third,
	output logic [52:0]            sum_fourth
);

	localparam logic [8:0] CAP = 9'(MAX_SAMPLES);

	logic signed [11:0] xe;
	logic               take;
	logic               v_s1_q, v_s2_q;
	logic signed [11:0] x_s1, x_s2;
	logic signed [23:0] sq_s1, sq_s2;
	logic signed [35:0] cube_s2;
	logic [47:0]        quad_s2;
	logic [8:0]         count_q;
	logic signed [19:0] s1_q;
	logic [30:0]        s2_q;
	logic signed [41:0] s3_q;
	logic [52:0]        s4_q;

	assign xe = 12'($signed(sample[SAMPLE_BITS-1:0]));
	assign take = add && (count_q < CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			count_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
			s3_q <= '0;
			s4_q <= '0;
		end else begin
			v_s1_q <= take;
			v_s2_q <= v_s1_q;
			if (clr) begin
				count_q <= '0;
				s1_q <= '0;
				s2_q <= '0;
				s3_q <= '0;
				s4_q <= '0;
			end else begin
				if (take)
					count_q <= count_q + 9'd1;
				if (v_s2_q) begin
					s1_q <= s1_q + 20'(x_s2);
					s2_q <= s2_q + 31'(sq_s2);
					s3_q <= s3_q + 42'(cube_s2);
					s4_q <= s4_q + 53'(quad_s2);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= xe;
		sq_s1 <= xe * xe;
		x_s2 <= x_s1;
		sq_s2 <= sq_s1;
		cube_s2 <= sq_s1 * x_s1;
		quad_s2 <= sq_s1 * sq_s1;
	end

	assign status.pipe_busy = v_s1_q || v_s2_q;
	assign status.at_cap = (count_q == CAP);
	assign count = count_q;
	assign sum_first = s1_q;
	assign sum_second = s2_q;
	assign sum_third = s3_q;
	assign sum_fourth = s4_q;

endmodule

FILE: hw/rtl/jbs_alu.sv
// jbs_alu: shared wide unit: add, subtract, shift-add multiply (mod 2^W) and
// restoring unsigned divide, one bit per cycle. Depends on jbs_pkg.
module jbs_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  jbs_pkg::alu_req_t req,
	input  jbs_pkg::wide_t    a,
	input  jbs_pkg::wide_t    b,
	output logic              busy,
	output logic              done,
	output jbs_pkg::wide_t    y
);

	localparam int W = jbs_pkg::W;
	localparam int CNT_BITS = $clog2(W + 1);

	logic            busy_q, done_q;
	jbs_pkg::op_t    op_q;
	logic [CNT_BITS-1:0] cnt_q;
	jbs_pkg::wide_t  acc_q, mc_q, mp_q, y_q;
	logic [W:0]      rem_q;
	jbs_pkg::wide_t  acc_n;
	logic [W:0]      rem_sh;
	logic [W+1:0]    diff;
	logic            ge;

	assign acc_n = mp_q[0] ? acc_q + mc_q : acc_q;
	// divide: mp_q shifts the dividend out on top and the quotient in below
	assign rem_sh = {rem_q[W-1:0], mp_q[W-1]};
	assign diff = {1'b0, rem_sh} - {2'b00, mc_q};
	assign ge = ~diff[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= jbs_pkg::OP_ADD;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				cnt_q <= CNT_BITS'(W);
				case (req.op)
					jbs_pkg::OP_MUL, jbs_pkg::OP_DIV: busy_q <= 1'b1;
					default: done_q <= 1'b1;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				case (op_q)
					jbs_pkg::OP_MUL: begin
						if (mp_q[W-1:1] == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						if (cnt_q == CNT_BITS'(1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			case (req.op)
				jbs_pkg::OP_ADD: y_q <= a + b;
				jbs_pkg::OP_SUB: y_q <= a - b;
				jbs_pkg::OP_MUL: begin
					acc_q <= '0;
					mc_q <= a;
					mp_q <= b;
				end
				default: begin
					rem_q <= '0;
					mp_q <= a;
					mc_q <= b;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				jbs_pkg::OP_MUL: begin
					acc_q <= acc_n;
					mc_q <= {mc_q[W-2:0], 1'b0};
					mp_q <= {1'b0, mp_q[W-1:1]};
					y_q <= acc_n;
				end
				default: begin
					rem_q <= ge ? diff[W:0] : rem_sh;
					mp_q <= {mp_q[W-2:0], ge};
					y_q <= {mp_q[W-2:0], ge};
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign y = y_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("alu started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("alu done while still busy");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (op_q == jbs_pkg::OP_DIV) |-> cnt_q != '0)
		else $error("divide step count ran out");

endmodule

FILE: hw/rtl/jarque_bera_statistic.sv
// jarque_bera_statistic: top level; sequencer, register file and output word.
// Depends on jbs_pkg, jbs_accum and jbs_alu.
//
// Samples are taken one per cycle while a run is open. The flagged last
// sample closes the run: the power pipeline drains, count and sums load
// into the register file, then a 38-step program runs on one shared wide
// unit (it ends early on zero variance). Each step is fetched, issued and
// executed; a multiply steps only up to its multiplier's highest set bit,
// the final divide through every bit. The bit-serial multiplier and divider
// set the finish time; input stalls for all of it. The result word is held
// in an output register until taken.
module jarque_bera_statistic #(
	parameter int MAX_SAMPLES = 256,
	parameter int SAMPLE_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] sample,
	input  logic        last_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] jb_value,
	output logic        saturated,
	output logic        degenerate,
	output logic [8:0]  sample_count
);

	localparam int W = jbs_pkg::W;

	typedef enum logic [6:0] {
		ST_ACC   = 7'b0000001,
		ST_DRAIN = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_FETCH = 7'b0001000,
		ST_ISSUE = 7'b0010000,
		ST_EXEC  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t               state_q;
	jbs_pkg::pc_t         pc_q;
	logic [2:0]           ld_cnt_q;
	logic                 deg_q;
	logic                 out_valid_q;
	logic [31:0]          jb_q;
	logic                 sat_q, degout_q;
	logic [8:0]           cnt_out_q;

	logic                 accept, clr, out_take;
	jbs_pkg::acc_status_t acc_st;
	logic [8:0]           count;
	logic signed [19:0]   s1;
	logic [30:0]          s2;
	logic signed [41:0]   s3;
	logic [52:0]          s4;

	jbs_pkg::instr_t      ins;
	jbs_pkg::alu_req_t    alu_req;
	jbs_pkg::wide_t       alu_b, alu_y, ld_data, wd, rda_q, rdb_q;
	logic                 alu_busy, alu_done, we;
	jbs_pkg::raddr_t      wa;
	jbs_pkg::wide_t       rf [16];

	assign in_stall = (state_q != ST_ACC);
	assign accept = in_valid && !in_stall;
	assign out_take = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign clr = out_take;

	jbs_accum #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.add(accept),
		.sample(sample),
		.clr(clr),
		.status(acc_st),
		.count(count),
		.sum_first(s1),
		.sum_second(s2),
		.sum_third(s3),
		.sum_fourth(s4)
	);

	assign ins = jbs_pkg::prog(pc_q);
	assign alu_req.start = (state_q == ST_ISSUE);
	assign alu_req.op = ins.op;
	assign alu_b = ins.use_imm ? jbs_pkg::wide_t'(ins.imm) : rdb_q;

	jbs_alu u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.req(alu_req),
		.a(rda_q),
		.b(alu_b),
		.busy(alu_busy),
		.done(alu_done),
		.y(alu_y)
	);

	always_comb begin
		case (ld_cnt_q)
			3'd0: ld_data = jbs_pkg::wide_t'(count);
			3'd1: ld_data = jbs_pkg::wide_t'(s1);
			3'd2: ld_data = jbs_pkg::wide_t'(s2);
			3'd3: ld_data = jbs_pkg::wide_t'(s3);
			default: ld_data = jbs_pkg::wide_t'(s4);
		endcase
	end

	assign we = (state_q == ST_LOAD) || ((state_q == ST_EXEC) && alu_done);
	assign wa = (state_q == ST_LOAD) ? jbs_pkg::raddr_t'(ld_cnt_q) : ins.dst;
	assign wd = (state_q == ST_LOAD) ? ld_data : alu_y;

	always_ff @(posedge clk) begin
		if (we)
			rf[wa] <= wd;
		rda_q <= rf[ins.ra];
		rdb_q <= rf[ins.rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			pc_q <= '0;
			ld_cnt_q <= '0;
			deg_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_take)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_ACC: begin
					if (accept && last_sample)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					ld_cnt_q <= '0;
					if (!acc_st.pipe_busy)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					ld_cnt_q <= ld_cnt_q + 3'd1;
					if (ld_cnt_q == 3'd4) begin
						pc_q <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: state_q <= ST_ISSUE;
				ST_ISSUE: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (alu_done) begin
						// zero variance ends the program early
						if (pc_q == jbs_pkg::PC_M2 && alu_y == '0) begin
							deg_q <= 1'b1;
							state_q <= ST_OUT;
						end else if (pc_q == jbs_pkg::PC_LAST) begin
							deg_q <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							pc_q <= pc_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_OUT: begin
					if (out_take)
						state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	// degenerate leaves alu_y at zero, so value and flag fall out as zero
	always_ff @(posedge clk) begin
		if (out_take) begin
			sat_q <= |alu_y[W-1:32];
			jb_q <= (|alu_y[W-1:32]) ? '1 : alu_y[31:0];
			degout_q <= deg_q;
			cnt_out_q <= count;
		end
	end

	assign out_valid = out_valid_q;
	assign jb_value = jb_q;
	assign saturated = sat_q;
	assign degenerate = degout_q;
	assign sample_count = cnt_out_q;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && degout_q |-> (jb_q == '0) && !sat_q)
		else $error("degenerate word carries a value");
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sat_q |-> jb_q == '1)
		else $error("saturated word not at maximum");
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> !acc_st.pipe_busy)
		else $error("sums loaded before pipeline drained");
	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> cnt_out_q != '0)
		else $error("result word with empty run");
	a_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> !alu_busy)
		else $error("step issued while unit busy");

endmodule

FILE: sim/tb.sv
// tb: self-checking testbench for jarque_bera_statistic.
// Drives sample runs over valid/stall, predicts each statistic in wide integers
// and compares it field by field; depends only on the RTL top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] jb;
		logic        sat;
		logic        deg;
		logic [8:0]  cnt;
	} jb_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [11:0] sample = '0;
	logic        last_sample = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] jb_value;
	logic        saturated;
	logic        degenerate;
	logic [8:0]  sample_count;

	jb_word_t    jb_expected[$];
	int          fails = 0;
	bit          quiet = 0;      // no idling on either side
	int          hold_cycles = 0;

	// running sums of the open run
	int unsigned run_count = 0;
	longint      run_s1 = 0, run_s2 = 0, run_s3 = 0, run_s4 = 0;

	jarque_bera_statistic dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .last_sample(last_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.jb_value(jb_value), .saturated(saturated),
		.degenerate(degenerate), .sample_count(sample_count)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		if (quiet || $urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic jb_word_t close_run();
		jb_word_t r;
		logic signed [255:0] n, a, m2, m3, m4, t;
		logic [255:0] num, den, q;
		n = run_count;
		a = run_s1;
		m2 = n * run_s2 - a * a;
		r.cnt = run_count[8:0];
		r.sat = 1'b0;
		r.deg = 1'b0;
		r.jb = '0;
		if (m2 == 0) begin
			r.deg = 1'b1;
		end else begin
			m3 = n * n * run_s3 - 3 * n * a * run_s2 + 2 * a * a * a;
			m4 = n * n * n * run_s4 - 4 * n * n * a * run_s3
				+ 6 * n * a * a * run_s2 - 3 * a * a * a * a;
			t = m4 - 3 * m2 * m2;
			num = n * 65536 * (4 * m3 * m3 * m2 + t * t);
			den = 24 * m2 * m2 * m2 * m2;
			q = num / den;
			if (q[255:32] != 0) begin
				r.sat = 1'b1;
				r.jb = 32'hFFFF_FFFF;
			end else begin
				r.jb = q[31:0];
			end
		end
		return r;
	endfunction

	function automatic void accumulate(logic [11:0] s, logic lst);
		longint x;
		x = $signed(s);
		if (run_count < 256) begin
			run_count++;
			run_s1 += x;
			run_s2 += x * x;
			run_s3 += x * x * x;
			run_s4 += x * x * x * x;
		end
		if (lst) begin
			jb_expected.push_back(close_run());
			run_count = 0;
			run_s1 = 0; run_s2 = 0; run_s3 = 0; run_s4 = 0;
		end
	endfunction

	// sends one word; valid stays high into the next word when there is no gap
	task automatic send_word(logic [11:0] s, logic lst);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		last_sample <= lst;
		do @(posedge clk); while (in_stall);
		accumulate(s, lst);
		@(negedge clk);
	endtask

	task automatic send_run(int len, int lo, int hi);
		for (int i = 0; i < len; i++)
			send_word(12'($urandom_range(0, hi - lo) + lo), i == len - 1);
	endtask

	task automatic send_idle();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_word(12'd5, 1'b1);                       // single sample: degenerate
		send_word(12'h800, 1'b0); send_word(12'h800, 1'b0);
		send_word(12'h800, 1'b1);                     // constant run: degenerate
		send_word(12'h800, 1'b0); send_word(12'h7FF, 1'b1);   // two extremes
		send_word(12'h7FF, 1'b0); send_word(12'h800, 1'b0);
		send_word(12'hFFF, 1'b0); send_word(12'h000, 1'b0);
		send_word(12'h001, 1'b0); send_word(12'h555, 1'b0);
		send_word(12'hAAA, 1'b1);
		for (int i = 0; i < 8; i++)
			send_word(12'd0, 1'b0);
		send_word(12'h7FF, 1'b1);                     // lone outlier: large value
		send_idle();
	endtask

	task automatic test_saturation();
		// full run of zeros and one outlier: statistic far past Q16.16 range
		for (int i = 0; i < 255; i++)
			send_word(12'd0, 1'b0);
		send_word(12'h800, 1'b1);
		send_idle();
	endtask

	task automatic test_over_cap();
		// words beyond the capacity are dropped, the flagged one still closes
		send_run(260, -2048, 2047);
		send_idle();
	endtask

	task automatic test_random();
		int len, lo, hi;
		for (int r = 0; r < 20; r++) begin
			quiet = ($urandom_range(0, 7) == 0);
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 10) : $urandom_range(11, 64);
			case ($urandom_range(0, 3))
				0: begin lo = -2048; hi = 2047; end
				1: begin lo = -4; hi = 4; end
				2: begin lo = 2000; hi = 2047; end
				default: begin lo = $urandom_range(0, 100) - 50; hi = lo + $urandom_range(0, 3); end
			endcase
			send_run(len, lo, hi);
		end
		quiet = 0;
		send_idle();
	endtask

	task automatic test_backpressure();
		wait (jb_expected.size() == 0);
		hold_cycles = 20000;
		for (int r = 0; r < 4; r++)
			send_run($urandom_range(2, 5), -300, 300);
		send_idle();
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 9) < 3 || $urandom_range(0, 49) == 0);
		end
	end

	always @(posedge clk) begin
		jb_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (jb_expected.size() == 0) begin
				$error("result word with none expected");
				fails++;
			end else begin
				e = jb_expected.pop_front();
				if (jb_value !== e.jb) begin
					$error("jb_value expected %h got %h", e.jb, jb_value); fails++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %b got %b", e.sat, saturated); fails++;
				end
				if (degenerate !== e.deg) begin
					$error("degenerate expected %b got %b", e.deg, degenerate); fails++;
				end
				if (sample_count !== e.cnt) begin
					$error("sample_count expected %0d got %0d", e.cnt, sample_count); fails++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_saturation();
		test_over_cap();
		test_random();
		test_backpressure();
		wait (jb_expected.size() == 0);
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
